FILE: src/pfr_pkg.sv
// ============================================================================
// pfr_pkg : shared types and constants of the polyphase resampler
// Holds the fixed filter geometry, fixed-point formats, the command and
// status bundles between controller and datapath, and the output rounding.
// ============================================================================
package pfr_pkg;

    // Filter geometry
    localparam int INTERP_FACTOR  = 8;
    localparam int TAPS_PER_PHASE = 256;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 18;
    localparam int PHASE_W        = $clog2(INTERP_FACTOR);
    localparam int TAP_W          = $clog2(TAPS_PER_PHASE);
    localparam int COEF_DEPTH     = TAPS_PER_PHASE * INTERP_FACTOR;
    localparam int COEF_AW        = $clog2(COEF_DEPTH);
    localparam int FILL_W         = TAP_W + 1;
    localparam int MAX_OUT        = 8;
    localparam int CNT_W          = $clog2(MAX_OUT);

    // Stream field widths
    localparam int IDX_W   = 11;
    localparam int TDATA_W = 64;
    localparam int ODATA_W = 2 * SAMPLE_BITS;
    localparam int WIN_W   = 2 * SAMPLE_BITS;

    // Phase accumulator, Q16
    localparam int STEP_W     = 23;
    localparam int ACC_W      = STEP_W + 1;
    localparam int Q16_FRAC   = 16;
    localparam int Q16_ONE    = 65536;
    localparam int Q16_HALF   = 32768;
    localparam int STEP_RESET = 524288;
    localparam int STEP_MIN   = 65536;
    localparam int STEP_MAX   = 4194304;

    // Multiply-accumulate
    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
    localparam int MAC_W  = PROD_W + TAP_W;
    localparam int Q_W    = MAC_W - COEF_BITS + 1;

    localparam logic signed [MAC_W-1:0] ROUND_BIAS = MAC_W'(1) << (COEF_BITS - 2);
    localparam logic signed [Q_W-1:0]   SAT_HI     = Q_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_W-1:0]   SAT_LO     = ~SAT_HI;

    // Controller to datapath commands
    typedef struct packed {
        logic             coef_wr;   // write the offered coefficient
        logic             latch;     // capture the offered sample
        logic             take;      // grab phase, step accumulator, clear sums
        logic             issue;     // read one tap pair
        logic [TAP_W-1:0] tap;       // tap being read
        logic             emit;      // load the output register
        logic             last;      // flag of the result being loaded
        logic             store;     // push sample into window, advance phase
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic full;      // window holds a full set of samples
        logic phase_ok;  // accumulator still calls for an output
        logic busy;      // multiply-accumulate pipeline not yet drained
        logic out_free;  // output register can take a new result
    } t_sts;

    // Round half up, drop COEF_BITS-1 fraction bits, clamp to sample range
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [MAC_W-1:0] a
    );
        logic signed [MAC_W-1:0] v;
        logic signed [Q_W-1:0]   q;
        logic signed [Q_W-1:0]   c;
        v = a + ROUND_BIAS;
        q = v[MAC_W-1:COEF_BITS-1];
        if (q > SAT_HI) begin
            c = SAT_HI;
        end else if (q < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = q;
        end
        return c[SAMPLE_BITS-1:0];
    endfunction

endpackage

FILE: src/pfr_ram.sv
// ============================================================================
// pfr_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module pfr_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/pfr_ctrl.sv
// ============================================================================
// pfr_ctrl : sequencing state machine of the resampler
// Accepts items, walks the taps of each output, waits for the pipeline and
// the output register, and closes every sample with a window push.
// ============================================================================
module pfr_ctrl
    import pfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_mode,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_MAC   = 6'b000100,
        S_DRAIN = 6'b001000,
        S_EMIT  = 6'b010000,
        S_STORE = 6'b100000
    } t_state;

    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAPS_PER_PHASE - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_OUT - 1);

    t_state           r_state, n_state;
    logic [TAP_W-1:0] r_tap, n_tap;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_last;

    assign w_last     = (r_cnt == CNT_LAST) || !i_sts.phase_ok;
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.tap  = r_tap;
        o_cmd.last = w_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_mode) begin
                        o_cmd.coef_wr = 1'b1;
                    end else begin
                        o_cmd.latch = 1'b1;
                        n_cnt       = '0;
                        n_state     = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.full && i_sts.phase_ok) begin
                    o_cmd.take = 1'b1;
                    n_tap      = '0;
                    n_state    = S_MAC;
                end else begin
                    n_state = S_STORE;
                end
            end
            S_MAC: begin
                o_cmd.issue = 1'b1;
                n_tap       = r_tap + 1'b1;
                if (r_tap == TAP_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_cnt      = r_cnt + 1'b1;
                    n_state    = w_last ? S_STORE : S_CHECK;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: src/pfr_datapath.sv
// ============================================================================
// pfr_datapath : storage and arithmetic of the resampler
// Coefficient and window RAMs, phase accumulator, a complex
// multiply-accumulate pipeline and the output register.
// ============================================================================
module pfr_datapath
    import pfr_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [STEP_W-1:0]             i_cfg_wr_data,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_i,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_q,
    input  logic [IDX_W-1:0]              i_coef_index,
    input  logic signed [COEF_BITS-1:0]   i_coef_value,
    input  t_cmd                          i_cmd,
    output t_sts                          o_sts,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_out_i,
    output logic signed [SAMPLE_BITS-1:0] o_out_q,
    output logic                          o_out_last
);

    localparam logic signed [ACC_W:0]   T_HALF    = (ACC_W + 1)'(Q16_HALF);
    localparam logic signed [ACC_W:0]   T_NEG_ONE = (ACC_W + 1)'(-Q16_ONE);
    localparam logic signed [ACC_W-1:0] ACC_INC   = ACC_W'(INTERP_FACTOR * Q16_ONE);
    localparam logic [ACC_W-Q16_FRAC:0] PHASE_TOP = (ACC_W - Q16_FRAC + 1)'(INTERP_FACTOR - 1);
    localparam logic [FILL_W-1:0]       FILL_FULL = FILL_W'(TAPS_PER_PHASE);

    // Control-side state
    logic [STEP_W-1:0]             r_step;
    logic signed [ACC_W-1:0]       r_acc;
    logic [FILL_W-1:0]             r_fill;
    logic [TAP_W-1:0]              r_wr_ptr;
    logic [PHASE_W-1:0]            r_phase;
    logic signed [SAMPLE_BITS-1:0] r_smp_i, r_smp_q;

    // Pipeline
    logic                          r_v1, r_v2;
    logic signed [PROD_W-1:0]      r_prod_i, r_prod_q;
    logic signed [MAC_W-1:0]       r_mac_i, r_mac_q;

    // Output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_i, r_out_q;
    logic                          r_out_last;

    logic [STEP_W-1:0]             w_eff_step;
    logic signed [ACC_W-1:0]       w_step_s;
    logic signed [ACC_W:0]         w_t;
    logic [ACC_W-Q16_FRAC:0]       w_t_int;
    logic [PHASE_W-1:0]            w_phase;
    logic                          w_full;
    logic [COEF_BITS-1:0]          w_coef_rd;
    logic [WIN_W-1:0]              w_win_rd;
    logic signed [COEF_BITS-1:0]   w_coef;
    logic signed [SAMPLE_BITS-1:0] w_win_i, w_win_q;
    logic                          w_out_xfer;

    // Clamp the programmed step
    always_comb begin
        priority if (r_step < STEP_W'(STEP_MIN)) begin
            w_eff_step = STEP_W'(STEP_MIN);
        end else if (r_step > STEP_W'(STEP_MAX)) begin
            w_eff_step = STEP_W'(STEP_MAX);
        end else begin
            w_eff_step = r_step;
        end
    end
    assign w_step_s = $signed({1'b0, w_eff_step});

    // Round the accumulator to a phase branch
    assign w_t     = (ACC_W + 1)'(r_acc) + T_HALF;
    assign w_t_int = w_t[ACC_W:Q16_FRAC];
    always_comb begin
        priority if (w_t < 0) begin
            w_phase = '0;
        end else if (w_t_int > PHASE_TOP) begin
            w_phase = PHASE_TOP[PHASE_W-1:0];
        end else begin
            w_phase = w_t_int[PHASE_W-1:0];
        end
    end

    assign w_full      = (r_fill == FILL_FULL);
    assign w_out_xfer  = r_out_valid && i_out_ready;

    assign o_sts.full     = w_full;
    assign o_sts.phase_ok = (w_t > T_NEG_ONE);
    assign o_sts.busy     = r_v1 || r_v2;
    assign o_sts.out_free = !r_out_valid || w_out_xfer;

    // Coefficient store: tap k of phase p at k*INTERP_FACTOR+p
    pfr_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.coef_wr && (32'(i_coef_index) < 32'(COEF_DEPTH))),
        .i_wr_addr (i_coef_index[COEF_AW-1:0]),
        .i_wr_data (i_coef_value),
        .i_rd_addr ({i_cmd.tap, r_phase}),
        .o_rd_data (w_coef_rd)
    );

    // Sample window, circular, oldest entry at the write pointer
    pfr_ram #(
        .WIDTH (WIN_W),
        .DEPTH (TAPS_PER_PHASE)
    ) u_win_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.store),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data ({r_smp_q, r_smp_i}),
        .i_rd_addr (r_wr_ptr + i_cmd.tap),
        .o_rd_data (w_win_rd)
    );

    assign w_coef  = w_coef_rd;
    assign w_win_i = w_win_rd[SAMPLE_BITS-1:0];
    assign w_win_q = w_win_rd[WIN_W-1:SAMPLE_BITS];

    // Step register, phase accumulator, fill count and write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_W'(STEP_RESET);
            r_acc    <= '0;
            r_fill   <= '0;
            r_wr_ptr <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_step <= i_cfg_wr_data;
            end
            if (i_cmd.take) begin
                r_acc <= r_acc - w_step_s;
            end else if (i_cmd.store && w_full) begin
                r_acc <= r_acc + ACC_INC;
            end
            if (i_cmd.store) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
                if (!w_full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    // Hold sample and selected phase
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_smp_i <= i_sample_i;
            r_smp_q <= i_sample_q;
        end
        if (i_cmd.take) begin
            r_phase <= w_phase;
        end
    end

    // Pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    // Multiply, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod_i <= w_coef * w_win_i;
        r_prod_q <= w_coef * w_win_q;
        if (i_cmd.take) begin
            r_mac_i <= '0;
            r_mac_q <= '0;
        end else if (r_v2) begin
            r_mac_i <= r_mac_i + MAC_W'(r_prod_i);
            r_mac_q <= r_mac_q + MAC_W'(r_prod_q);
        end
    end

    // Output register: load on emit, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_i    <= round_sat(r_mac_i);
            r_out_q    <= round_sat(r_mac_q);
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_i     = r_out_i;
    assign o_out_q     = r_out_q;
    assign o_out_last  = r_out_last;

endmodule

FILE: src/polyphase_fractional_resampler_core.sv
// ============================================================================
// polyphase_fractional_resampler_core : rational resampler, 8 phase branches
// Complex samples go into a 256-entry window; a Q16 phase accumulator picks
// the branch of each output, and one shared complex multiply-accumulate
// computes the 256-tap dot product, rounded and saturated to 16 bits.
// ============================================================================
//
//  Channel  | Direction | Payload
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tuser: mode; tdata: sample_i, sample_q,
//           |           |   coef_index, coef_value
//  m_axis   | out       | tdata: out_i, out_q; tlast: last
//  i_cfg    | in        | step_ratio, written when i_cfg_wr_en is high
//
//  A coefficient write is taken straight from the idle state. A sample that
//  makes no output goes straight to its window push; one that makes n outputs
//  takes, per output, one phase check, 256 tap reads through the shared
//  multiply-accumulate, a drain of its two-stage pipeline and one load of the
//  output register, up to 8 outputs. The output register holds one result; a
//  stalled m_axis holds the next output at its load step. Reset is synchronous
//  and active low; the RAMs are not cleared.
//
module polyphase_fractional_resampler_core
    import pfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // step_ratio
    input  logic               i_cfg_wr_en,
    input  logic [STEP_W-1:0]  i_cfg_wr_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [15:0] sample_i, [31:16] sample_q, [42:32] coef_index,
    // [60:43] coef_value, [63:61] zero
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // [0] mode
    input  logic               s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [15:0] out_i, [31:16] out_q
    output logic [ODATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tlast
);

    localparam int SQ_LO = SAMPLE_BITS;
    localparam int IX_LO = 2 * SAMPLE_BITS;
    localparam int CV_LO = IX_LO + IDX_W;

    t_cmd                          w_cmd;
    t_sts                          w_sts;
    logic signed [SAMPLE_BITS-1:0] w_out_i, w_out_q;

    // Sequencer
    pfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Storage and arithmetic
    pfr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sample_i    (s_axis_tdata[SQ_LO-1:0]),
        .i_sample_q    (s_axis_tdata[IX_LO-1:SQ_LO]),
        .i_coef_index  (s_axis_tdata[CV_LO-1:IX_LO]),
        .i_coef_value  (s_axis_tdata[CV_LO+COEF_BITS-1:CV_LO]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_i       (w_out_i),
        .o_out_q       (w_out_q),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {w_out_q, w_out_i};

endmodule

FILE: src/pfr_checker.sv
// ============================================================================
// pfr_checker : port-level checks of the resampler
// Watches the stream and reset behavior and is bound to the top level.
// ============================================================================
module pfr_checker
    import pfr_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               s_axis_tuser,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [ODATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

    // Ready again in the cycle after a coefficient write
    a_coef_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> s_axis_tready)
        else $error("not ready after coefficient write");

    // Sample transfer starts processing
    a_smp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
        else $error("ready right after sample transfer");

endmodule

bind polyphase_fractional_resampler_core pfr_checker u_pfr_checker (.*);
